// ===== hdl/rdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdcc_pkg
// Shared constants, codes, types and helpers for the region colour classifier.
// ----------------------------------------------------------------------------
package rdcc_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;

    localparam int CHAN_W      = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CODE_W      = 2;
    localparam int COUNT_W     = 19;
    localparam int NUM_REGIONS = 3;
    localparam int NUM_COLORS  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int RESET_FRAME_WIDTH = 640;
    localparam logic [CHAN_W-1:0] RESET_STRONG_MIN = 8'd200;
    localparam logic [CHAN_W-1:0] RESET_WEAK_MAX   = 8'd50;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRONG_MIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEAK_MAX    = 2'd2;

    // region codes
    localparam logic [CODE_W-1:0] REGION_RIGHT  = 2'd0;
    localparam logic [CODE_W-1:0] REGION_CENTER = 2'd1;
    localparam logic [CODE_W-1:0] REGION_LEFT   = 2'd2;
    localparam logic [CODE_W-1:0] REGION_NONE   = 2'd3;

    // colour codes
    localparam logic [CODE_W-1:0] COLOR_BLUE  = 2'd0;
    localparam logic [CODE_W-1:0] COLOR_GREEN = 2'd1;
    localparam logic [CODE_W-1:0] COLOR_RED   = 2'd2;

    // floor(v/3) by reciprocal, exact for v < 2**17
    localparam int DIV3_SHIFT = 18;
    localparam logic [16:0] DIV3_MUL = 17'((2**DIV3_SHIFT + 2) / 3);

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        t_code [NUM_REGIONS-1:0] color;
    } t_verdict;

    typedef struct packed {
        logic     valid;
        t_verdict verdict;
    } t_qslot;

    function automatic logic [15:0] div3(input logic [15:0] v);
        logic [33:0] p;
        p = 34'(v) * 34'(DIV3_MUL);
        return p[33:DIV3_SHIFT];
    endfunction

endpackage

// ===== hdl/rdcc_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rdcc_pixel_if
// Pixel item channel: valid/ready with the three channels and end of frame.
// ----------------------------------------------------------------------------
interface rdcc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [rdcc_pkg::CHAN_W-1:0] blue_value;
    logic [rdcc_pkg::CHAN_W-1:0] green_value;
    logic [rdcc_pkg::CHAN_W-1:0] red_value;
    logic                      end_of_frame;

    modport source (output valid, blue_value, green_value, red_value, end_of_frame,
                    input ready);
    modport sink   (input valid, blue_value, green_value, red_value, end_of_frame,
                    output ready);
endinterface

// ===== hdl/rdcc_result_if.sv =====
// ----------------------------------------------------------------------------
// rdcc_result_if
// Result item channel: valid/ready with region, colour and last flag.
// ----------------------------------------------------------------------------
interface rdcc_result_if;
    logic                      valid;
    logic                      ready;
    logic [rdcc_pkg::CODE_W-1:0] region;
    logic [rdcc_pkg::CODE_W-1:0] dominant_color;
    logic                      last_region;

    modport source (output valid, region, dominant_color, last_region, input ready);
    modport sink   (input valid, region, dominant_color, last_region, output ready);
endinterface

// ===== hdl/region_dominant_color_classifier.sv =====
// ----------------------------------------------------------------------------
// region_dominant_color_classifier
// Counts pure red/green/blue pixels in the left, centre and right thirds of a
// frame and reports the dominant colour of each region at end of frame.
//
//   port     dir  kind        carries
//   i_pix    in   valid/ready blue_value, green_value, red_value, end_of_frame
//   o_res    out  valid/ready region, dominant_color, last_region
//   i_cfg_*  in   write only  frame_width (0), strong_min (1), weak_max (2)
//
// One pixel item per cycle unless an end-of-frame item waits on a full queue;
// the counter update stage sets the pace. Results pass the snapshot, queue and
// output register, right, centre, left. The two-entry verdict queue holds
// frames while the output stalls; end-of-frame items faster than the back part
// unrolls verdicts eventually hold off the input. Synchronous active-low reset
// clears counters, column and queue, and loads the register defaults.
// ----------------------------------------------------------------------------
module region_dominant_color_classifier #(
    parameter int MAX_WIDTH = rdcc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rdcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rdcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rdcc_pixel_if.sink                       i_pix,
    rdcc_result_if.source                    o_res
);

    rdcc_pkg::t_qslot qwrite, qhead;
    logic             q_full, q_pop;

    rdcc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .pix         (i_pix),
        .o_qwrite    (qwrite),
        .i_q_full    (q_full)
    );

    rdcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (qwrite),
        .o_full  (q_full),
        .o_head  (qhead),
        .i_pop   (q_pop)
    );

    rdcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (qhead),
        .o_pop   (q_pop),
        .res     (o_res)
    );

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qwrite.valid |-> !q_full)
        else $error("verdict pushed into a full queue");

    a_last_is_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.last_region |-> o_res.region == rdcc_pkg::REGION_LEFT)
        else $error("last flag on a region other than left");

    a_right_then_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && o_res.region == rdcc_pkg::REGION_RIGHT
        |=> o_res.valid && o_res.region == rdcc_pkg::REGION_CENTER)
        else $error("centre item did not follow right");

    a_center_then_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && o_res.region == rdcc_pkg::REGION_CENTER
        |=> o_res.valid && o_res.region == rdcc_pkg::REGION_LEFT)
        else $error("left item did not follow centre");

endmodule

// ===== hdl/rdcc_front.sv =====
// ----------------------------------------------------------------------------
// rdcc_front
// Tracks the column, classifies pixels, keeps the per-region colour counts
// and turns each frame's counts into a verdict for the queue.
// ----------------------------------------------------------------------------
module rdcc_front #(
    parameter int MAX_WIDTH = rdcc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rdcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rdcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rdcc_pixel_if.sink                       pix,
    output rdcc_pkg::t_qslot                 o_qwrite,
    input  logic                             i_q_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RST_W      = (rdcc_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                                MAX_WIDTH : rdcc_pkg::RESET_FRAME_WIDTH;
    localparam int RST_THIRD  = RST_W / 3;
    localparam int RST_RSTART = (2 * RST_W) / 3;

    localparam int NR = rdcc_pkg::NUM_REGIONS;
    localparam int NC = rdcc_pkg::NUM_COLORS;

    // configuration and derived boundaries
    logic [WW-1:0]               r_width, r_third, r_third2, r_rstart, r_rend;
    logic [rdcc_pkg::CHAN_W-1:0] r_strong, r_weak;
    logic [WW-1:0]               cfg_w, cfg_third, cfg_rstart;

    // column and classify stage
    logic [CW-1:0]                r_col;
    logic [CW:0]                  col_p1;
    logic [WW-1:0]                col_x;
    logic                         r_c_valid, r_c_eof;
    rdcc_pkg::t_code              r_c_region, in_region;
    logic [NC-1:0]                r_c_pure, in_pure;
    logic                         pix_acc, c_advance, s_advance;

    // counters and frame snapshot
    logic [rdcc_pkg::COUNT_W-1:0] r_cnt  [NR][NC];
    logic [rdcc_pkg::COUNT_W-1:0] n_cnt  [NR][NC];
    logic [rdcc_pkg::COUNT_W-1:0] r_snap [NR][NC];
    logic                         r_s_valid;
    rdcc_pkg::t_verdict           verdict;

    // ---- configuration
    always_comb begin
        cfg_w      = (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(i_cfg_data);
        cfg_third  = WW'(rdcc_pkg::div3(16'(cfg_w)));
        cfg_rstart = WW'(rdcc_pkg::div3(16'({cfg_w, 1'b0})));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(RST_W);
            r_third  <= WW'(RST_THIRD);
            r_third2 <= WW'(2 * RST_THIRD);
            r_rstart <= WW'(RST_RSTART);
            r_rend   <= WW'(RST_RSTART + RST_THIRD);
            r_strong <= rdcc_pkg::RESET_STRONG_MIN;
            r_weak   <= rdcc_pkg::RESET_WEAK_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rdcc_pkg::CFG_FRAME_WIDTH: begin
                    r_width  <= cfg_w;
                    r_third  <= cfg_third;
                    r_third2 <= WW'({cfg_third, 1'b0});
                    r_rstart <= cfg_rstart;
                    r_rend   <= cfg_rstart + cfg_third;
                end
                rdcc_pkg::CFG_STRONG_MIN: r_strong <= i_cfg_data[rdcc_pkg::CHAN_W-1:0];
                rdcc_pkg::CFG_WEAK_MAX:   r_weak   <= i_cfg_data[rdcc_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- pixel classification at accept
    always_comb begin
        col_x = WW'(r_col);
        priority if (col_x < r_third) begin
            in_region = rdcc_pkg::REGION_LEFT;
        end else if (col_x < r_third2) begin
            in_region = rdcc_pkg::REGION_CENTER;
        end else if (col_x >= r_rstart && col_x < r_rend) begin
            in_region = rdcc_pkg::REGION_RIGHT;
        end else begin
            in_region = rdcc_pkg::REGION_NONE;
        end

        in_pure = '0;
        in_pure[rdcc_pkg::COLOR_RED]   = pix.red_value >= r_strong &&
                                         pix.green_value <= r_weak && pix.blue_value <= r_weak;
        in_pure[rdcc_pkg::COLOR_GREEN] = pix.green_value >= r_strong &&
                                         pix.red_value <= r_weak && pix.blue_value <= r_weak;
        in_pure[rdcc_pkg::COLOR_BLUE]  = pix.blue_value >= r_strong &&
                                         pix.red_value <= r_weak && pix.green_value <= r_weak;
        col_p1 = {1'b0, r_col} + (CW + 1)'(1);
    end

    assign s_advance = r_s_valid && !i_q_full;
    assign c_advance = r_c_valid && (!r_c_eof || !r_s_valid || s_advance);
    assign pix.ready = !r_c_valid || c_advance;
    assign pix_acc   = pix.valid && pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_c_valid <= 1'b0;
        end else begin
            if (pix_acc) begin
                if (pix.end_of_frame || 32'(col_p1) >= 32'(r_width)) begin
                    r_col <= '0;
                end else begin
                    r_col <= CW'(col_p1);
                end
            end
            if (pix.ready) begin
                r_c_valid <= pix.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_c_region <= in_region;
            r_c_pure   <= in_pure;
            r_c_eof    <= pix.end_of_frame;
        end
    end

    // ---- saturating counters
    always_comb begin
        for (int k = 0; k < NR; k++) begin
            for (int c = 0; c < NC; c++) begin
                if (r_c_region == rdcc_pkg::t_code'(k) && r_c_pure[c] &&
                    r_cnt[k][c] != rdcc_pkg::COUNT_MAX) begin
                    n_cnt[k][c] = r_cnt[k][c] + rdcc_pkg::COUNT_W'(1);
                end else begin
                    n_cnt[k][c] = r_cnt[k][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NR; k++) begin
                for (int c = 0; c < NC; c++) begin
                    r_cnt[k][c] <= '0;
                end
            end
            r_s_valid <= 1'b0;
        end else begin
            if (c_advance) begin
                for (int k = 0; k < NR; k++) begin
                    for (int c = 0; c < NC; c++) begin
                        r_cnt[k][c] <= r_c_eof ? '0 : n_cnt[k][c];
                    end
                end
            end
            if (c_advance && r_c_eof) begin
                r_s_valid <= 1'b1;
            end else if (s_advance) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_advance && r_c_eof) begin
            r_snap <= n_cnt;
        end
    end

    // ---- per-region decision
    always_comb begin
        for (int k = 0; k < NR; k++) begin
            priority if (r_snap[k][rdcc_pkg::COLOR_RED] > r_snap[k][rdcc_pkg::COLOR_GREEN] &&
                         r_snap[k][rdcc_pkg::COLOR_RED] > r_snap[k][rdcc_pkg::COLOR_BLUE]) begin
                verdict.color[k] = rdcc_pkg::COLOR_RED;
            end else if (r_snap[k][rdcc_pkg::COLOR_GREEN] > r_snap[k][rdcc_pkg::COLOR_RED] &&
                         r_snap[k][rdcc_pkg::COLOR_GREEN] > r_snap[k][rdcc_pkg::COLOR_BLUE]) begin
                verdict.color[k] = rdcc_pkg::COLOR_GREEN;
            end else begin
                verdict.color[k] = rdcc_pkg::COLOR_BLUE;
            end
        end
    end

    assign o_qwrite.valid   = s_advance;
    assign o_qwrite.verdict = verdict;

endmodule

// ===== hdl/rdcc_queue.sv =====
// ----------------------------------------------------------------------------
// rdcc_queue
// Short FIFO of frame verdicts between the front and back parts.
// ----------------------------------------------------------------------------
module rdcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rdcc_pkg::t_qslot i_write,
    output logic             o_full,
    output rdcc_pkg::t_qslot o_head,
    input  logic             i_pop
);

    localparam int DEPTH = rdcc_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    rdcc_pkg::t_verdict r_slot [DEPTH];
    logic [AW-1:0]      r_wptr, r_rptr;
    logic [NW-1:0]      r_count;
    logic               push, pop;

    assign push = i_write.valid && !o_full;
    assign pop  = i_pop && (r_count != '0);

    assign o_full         = (r_count == NW'(DEPTH));
    assign o_head.valid   = (r_count != '0);
    assign o_head.verdict = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + NW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_write.verdict;
        end
    end

endmodule

// ===== hdl/rdcc_back.sv =====
// ----------------------------------------------------------------------------
// rdcc_back
// Unrolls each frame verdict into three result items: right, centre, left.
// ----------------------------------------------------------------------------
module rdcc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rdcc_pkg::t_qslot i_head,
    output logic             o_pop,
    rdcc_result_if.source    res
);

    rdcc_pkg::t_code r_idx;
    logic            r_o_valid;
    rdcc_pkg::t_code r_o_region, r_o_color;
    logic            r_o_last;
    logic            load;

    assign load  = i_head.valid && (!r_o_valid || res.ready);
    assign o_pop = load && (r_idx == rdcc_pkg::REGION_LEFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= rdcc_pkg::REGION_RIGHT;
            r_o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= (r_idx == rdcc_pkg::REGION_LEFT) ? rdcc_pkg::REGION_RIGHT
                                                          : r_idx + rdcc_pkg::CODE_W'(1);
                r_o_valid <= 1'b1;
            end else if (res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_region <= r_idx;
            r_o_color  <= i_head.verdict.color[r_idx];
            r_o_last   <= (r_idx == rdcc_pkg::REGION_LEFT);
        end
    end

    assign res.valid          = r_o_valid;
    assign res.region         = r_o_region;
    assign res.dominant_color = r_o_color;
    assign res.last_region    = r_o_last;

endmodule

// ===== test/region_dominant_color_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// region_dominant_color_classifier_tb
// Drives pixel frames through the classifier under random source gaps and
// sink stalls, predicts the three region verdicts of each frame from its own
// column tracking and per-region tallies, and checks every result in order.
// ----------------------------------------------------------------------------
module region_dominant_color_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [rdcc_pkg::CHAN_W-1:0] blue;
        logic [rdcc_pkg::CHAN_W-1:0] green;
        logic [rdcc_pkg::CHAN_W-1:0] red;
        logic                        eof;
    } t_pixel;

    typedef struct packed {
        rdcc_pkg::t_code region;
        rdcc_pkg::t_code colour;
        logic            last;
    } t_result;

    typedef enum int {
        KIND_BLUE  = 0,
        KIND_GREEN = 1,
        KIND_RED   = 2,
        KIND_NOISE = 3
    } t_pix_kind;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [rdcc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rdcc_pkg::CFG_DATA_W-1:0]  cfg_data;

    rdcc_pixel_if  pix_if ();
    rdcc_result_if res_if ();

    region_dominant_color_classifier u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    // shadow of the block's registers and counting state
    logic [rdcc_pkg::CFG_DATA_W-1:0] cfg_width  =
        rdcc_pkg::CFG_DATA_W'(rdcc_pkg::RESET_FRAME_WIDTH);
    logic [rdcc_pkg::CHAN_W-1:0]     cfg_strong = rdcc_pkg::RESET_STRONG_MIN;
    logic [rdcc_pkg::CHAN_W-1:0]     cfg_weak   = rdcc_pkg::RESET_WEAK_MAX;
    int unsigned                     pixel_column = 0;
    logic [rdcc_pkg::COUNT_W-1:0]    colour_tally [rdcc_pkg::NUM_REGIONS][rdcc_pkg::NUM_COLORS];

    t_result expected_verdicts [$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int          sink_hold_left = 0;
    bit          src_idle_on   = 1'b1;
    bit          sink_idle_on  = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic int unsigned eff_width();
        return (cfg_width > rdcc_pkg::MAX_WIDTH_DEFAULT) ? rdcc_pkg::MAX_WIDTH_DEFAULT
                                                          : int'(cfg_width);
    endfunction

    function automatic rdcc_pkg::t_code region_at(input int unsigned col,
                                                  input int unsigned w);
        int unsigned third;
        int unsigned rstart;
        third  = w / 3;
        rstart = (2 * w) / 3;
        if (col < third)
            return rdcc_pkg::REGION_LEFT;
        if (col < 2 * third)
            return rdcc_pkg::REGION_CENTER;
        if (col >= rstart && col < rstart + third)
            return rdcc_pkg::REGION_RIGHT;
        return rdcc_pkg::REGION_NONE;
    endfunction

    function automatic void bump(input rdcc_pkg::t_code r, input rdcc_pkg::t_code c);
        if (colour_tally[r][c] != rdcc_pkg::COUNT_MAX)
            colour_tally[r][c]++;
    endfunction

    function automatic rdcc_pkg::t_code dominant(input rdcc_pkg::t_code r);
        logic [rdcc_pkg::COUNT_W-1:0] b;
        logic [rdcc_pkg::COUNT_W-1:0] g;
        logic [rdcc_pkg::COUNT_W-1:0] rd;
        b  = colour_tally[r][rdcc_pkg::COLOR_BLUE];
        g  = colour_tally[r][rdcc_pkg::COLOR_GREEN];
        rd = colour_tally[r][rdcc_pkg::COLOR_RED];
        if (rd > g && rd > b)
            return rdcc_pkg::COLOR_RED;
        if (g > rd && g > b)
            return rdcc_pkg::COLOR_GREEN;
        return rdcc_pkg::COLOR_BLUE;
    endfunction

    function automatic void clear_tallies();
        for (int r = 0; r < rdcc_pkg::NUM_REGIONS; r++)
            for (int c = 0; c < rdcc_pkg::NUM_COLORS; c++)
                colour_tally[r][c] = '0;
    endfunction

    function automatic void classify_pixel(input t_pixel px);
        int unsigned     w;
        rdcc_pkg::t_code reg_code;
        t_result         item;
        w        = eff_width();
        reg_code = region_at(pixel_column, w);
        if (reg_code != rdcc_pkg::REGION_NONE) begin
            if (px.red >= cfg_strong && px.green <= cfg_weak && px.blue <= cfg_weak)
                bump(reg_code, rdcc_pkg::COLOR_RED);
            if (px.green >= cfg_strong && px.red <= cfg_weak && px.blue <= cfg_weak)
                bump(reg_code, rdcc_pkg::COLOR_GREEN);
            if (px.blue >= cfg_strong && px.red <= cfg_weak && px.green <= cfg_weak)
                bump(reg_code, rdcc_pkg::COLOR_BLUE);
        end
        pixel_column++;
        if (pixel_column >= w)
            pixel_column = 0;
        if (px.eof) begin
            for (int k = 0; k < rdcc_pkg::NUM_REGIONS; k++) begin
                item = '{rdcc_pkg::t_code'(k), dominant(rdcc_pkg::t_code'(k)), k == 2};
                expected_verdicts.insert(expected_verdicts.size(), item);
            end
            clear_tallies();
            pixel_column = 0;
        end
    endfunction

    // ---------------- result side ----------------

    initial begin : result_sink
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_left > 0) begin
                res_if.ready <= 1'b0;
                sink_hold_left--;
            end else if (sink_idle_on && $urandom_range(0, 99) < 22) begin
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = expected_verdicts.pop_front();
                if (res_if.region !== want.region)
                    report_mismatch($sformatf("region %0d, expected %0d",
                                              res_if.region, want.region));
                if (res_if.dominant_color !== want.colour)
                    report_mismatch($sformatf("region %0d colour %0d, expected %0d",
                                              want.region, res_if.dominant_color,
                                              want.colour));
                if (res_if.last_region !== want.last)
                    report_mismatch($sformatf("region %0d last flag %b, expected %b",
                                              want.region, res_if.last_region, want.last));
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic t_pixel make_pixel(input t_pix_kind kind, input logic eof);
        t_pixel px;
        px.red   = rdcc_pkg::CHAN_W'($urandom_range(cfg_weak, 0));
        px.green = rdcc_pkg::CHAN_W'($urandom_range(cfg_weak, 0));
        px.blue  = rdcc_pkg::CHAN_W'($urandom_range(cfg_weak, 0));
        case (kind)
            KIND_RED:   px.red   = rdcc_pkg::CHAN_W'($urandom_range(255, cfg_strong));
            KIND_GREEN: px.green = rdcc_pkg::CHAN_W'($urandom_range(255, cfg_strong));
            KIND_BLUE:  px.blue  = rdcc_pkg::CHAN_W'($urandom_range(255, cfg_strong));
            default: begin
                px.red   = rdcc_pkg::CHAN_W'($urandom);
                px.green = rdcc_pkg::CHAN_W'($urandom);
                px.blue  = rdcc_pkg::CHAN_W'($urandom);
            end
        endcase
        px.eof = eof;
        return px;
    endfunction

    task automatic send_pixel(input t_pixel px);
        while (src_idle_on && $urandom_range(0, 99) < 22) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid        <= 1'b1;
        pix_if.blue_value   <= px.blue;
        pix_if.green_value  <= px.green;
        pix_if.red_value    <= px.red;
        pix_if.end_of_frame <= px.eof;
        @(posedge i_clk);
        while (pix_if.ready !== 1'b1)
            @(posedge i_clk);
        classify_pixel(px);
    endtask

    task automatic send_rgb(input int r, input int g, input int b, input logic eof);
        send_pixel('{rdcc_pkg::CHAN_W'(b), rdcc_pkg::CHAN_W'(g), rdcc_pkg::CHAN_W'(r), eof});
    endtask

    // kind chosen per pixel from the region its column falls in
    task automatic send_row(input int n, input t_pix_kind k_left, input t_pix_kind k_center,
                            input t_pix_kind k_right, input t_pix_kind k_none,
                            input bit end_frame);
        t_pix_kind kind;
        for (int i = 0; i < n; i++) begin
            case (region_at(pixel_column, eff_width()))
                rdcc_pkg::REGION_LEFT:   kind = k_left;
                rdcc_pkg::REGION_CENTER: kind = k_center;
                rdcc_pkg::REGION_RIGHT:  kind = k_right;
                default:                 kind = k_none;
            endcase
            send_pixel(make_pixel(kind, end_frame && i == n - 1));
        end
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [rdcc_pkg::CFG_INDEX_W-1:0] index,
                                  input int unsigned value);
        logic [rdcc_pkg::CFG_DATA_W-1:0] word;
        word = rdcc_pkg::CFG_DATA_W'(value);
        if (index != rdcc_pkg::CFG_FRAME_WIDTH)
            word[rdcc_pkg::CFG_DATA_W-1:rdcc_pkg::CHAN_W] =
                (rdcc_pkg::CFG_DATA_W - rdcc_pkg::CHAN_W)'($urandom);
        case (index)
            rdcc_pkg::CFG_FRAME_WIDTH: cfg_width  = word;
            rdcc_pkg::CFG_STRONG_MIN:  cfg_strong = word[rdcc_pkg::CHAN_W-1:0];
            rdcc_pkg::CFG_WEAK_MAX:    cfg_weak   = word[rdcc_pkg::CHAN_W-1:0];
            default: ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= word;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned s, input int unsigned k);
        write_register(rdcc_pkg::CFG_FRAME_WIDTH, w);
        write_register(rdcc_pkg::CFG_STRONG_MIN, s);
        write_register(rdcc_pkg::CFG_WEAK_MAX, k);
    endtask

    // ---------------- tests ----------------

    task automatic test_defaults();
        // threshold edges at the reset values, all within the left third
        send_rgb(200, 50, 50, 1'b0);
        send_rgb(255, 0, 0, 1'b0);
        send_rgb(50, 200, 50, 1'b0);
        send_rgb(199, 0, 0, 1'b0);
        send_rgb(255, 51, 0, 1'b0);
        send_rgb(50, 50, 200, 1'b1);
        wait_idle();
    endtask

    task automatic test_thresholds();
        configure(3, 255, 0);
        send_rgb(255, 0, 0, 1'b0);
        send_rgb(0, 255, 0, 1'b0);
        send_rgb(0, 0, 255, 1'b1);
        send_rgb(254, 0, 0, 1'b0);
        send_rgb(255, 1, 0, 1'b0);
        send_rgb(0, 0, 255, 1'b1);
        wait_idle();
        configure(3, 0, 255);
        send_row(3, KIND_NOISE, KIND_NOISE, KIND_NOISE, KIND_NOISE, 1'b1);
        wait_idle();
        // strong below weak: one pixel may count for two colours
        configure(3, 100, 150);
        send_rgb(120, 120, 0, 1'b0);
        send_rgb(0, 120, 120, 1'b0);
        send_rgb(120, 0, 120, 1'b0);
        send_rgb(200, 120, 0, 1'b0);
        send_rgb(0, 200, 120, 1'b0);
        send_rgb(120, 0, 120, 1'b1);
        wait_idle();
    endtask

    task automatic test_small_widths();
        for (int w = 0; w < 3; w++) begin
            configure(w, 200, 50);
            send_row(2, KIND_RED, KIND_RED, KIND_RED, KIND_RED, 1'b0);
            send_row(2, KIND_GREEN, KIND_GREEN, KIND_GREEN, KIND_GREEN, 1'b1);
            wait_idle();
        end
        // leftover columns must not count
        configure(5, 200, 50);
        send_row(10, KIND_RED, KIND_BLUE, KIND_GREEN, KIND_RED, 1'b1);
        wait_idle();
        configure(4, 200, 50);
        send_row(8, KIND_GREEN, KIND_RED, KIND_BLUE, KIND_GREEN, 1'b1);
        wait_idle();
        // width shrinks under a column already past it
        configure(12, 200, 50);
        send_row(9, KIND_RED, KIND_GREEN, KIND_BLUE, KIND_NOISE, 1'b0);
        wait_idle();
        write_register(rdcc_pkg::CFG_FRAME_WIDTH, 4);
        send_row(6, KIND_BLUE, KIND_GREEN, KIND_RED, KIND_RED, 1'b1);
        wait_idle();
    endtask

    task automatic test_wide_frames();
        configure(2047, 200, 50);
        send_row(8, KIND_RED, KIND_GREEN, KIND_BLUE, KIND_NOISE, 1'b1);
        wait_idle();
        configure(rdcc_pkg::MAX_WIDTH_DEFAULT, 180, 70);
        send_row(8, KIND_BLUE, KIND_RED, KIND_GREEN, KIND_NOISE, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned phase;
        int unsigned w;
        int unsigned sel;
        int unsigned s;
        int unsigned k;
        int unsigned len;
        int unsigned roll;
        t_pix_kind   bias [3];
        t_pix_kind   kind;
        phase  = 0;
        while (phase < 4) begin
            wait_idle();
            src_idle_on  = (phase != 3);
            sink_idle_on = (phase != 3);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                w = $urandom_range(0, 2);
            else if (sel == 1)
                w = $urandom_range(0, 2047);
            else if (sel == 2)
                w = rdcc_pkg::MAX_WIDTH_DEFAULT;
            else
                w = $urandom_range(3, 13);
            if ($urandom_range(0, 9) < 7) begin
                s = $urandom_range(120, 255);
                k = $urandom_range(0, 100);
            end else begin
                s = $urandom_range(0, 255);
                k = $urandom_range(0, 255);
            end
            configure(w, s, k);
            repeat ((phase == 3) ? 4 : $urandom_range(1, 2)) begin
                for (int r = 0; r < 3; r++)
                    bias[r] = t_pix_kind'($urandom_range(0, 3));
                len = (phase == 3) ? $urandom_range(6, 10) : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                        kind = KIND_NOISE;
                    else if (roll < 40)
                        kind = t_pix_kind'($urandom_range(0, 2));
                    else
                        case (region_at(pixel_column, eff_width()))
                            rdcc_pkg::REGION_LEFT:   kind = bias[0];
                            rdcc_pkg::REGION_CENTER: kind = bias[1];
                            rdcc_pkg::REGION_RIGHT:  kind = bias[2];
                            default:                 kind = KIND_NOISE;
                        endcase
                    send_pixel(make_pixel(kind, i == len - 1));
                end
            end
            phase++;
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_output_stall();
        configure(6, 200, 50);
        sink_hold_left = 300;
        repeat (12)
            send_pixel(make_pixel(t_pix_kind'($urandom_range(0, 3)), 1'b1));
        repeat (4)
            send_row(2, KIND_RED, KIND_GREEN, KIND_BLUE, KIND_NOISE, 1'b1);
        wait_idle();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pix_if.valid        = 1'b0;
        pix_if.blue_value   = '0;
        pix_if.green_value  = '0;
        pix_if.red_value    = '0;
        pix_if.end_of_frame = 1'b0;
        clear_tallies();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_thresholds();
        test_small_widths();
        test_wide_frames();
        test_random_frames();
        test_output_stall();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
